// ===== src/tlmc_pkg.sv =====
// tlmc_pkg: shared types and constants of the two-layer mlp classifier
// no dependencies; imported by tlmc_seq, tlmc_mac and the top level

package tlmc_pkg;

   localparam int VALUE_W    = 16;
   localparam int INDEX_W    = 9;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 40;
   localparam int LOGIT_W    = 32;
   localparam int CLASS_W    = 4;
   localparam int NEURON_W   = 5;
   localparam int FRAC_BITS  = 12;
   localparam int ROUND_HALF = 2048;
   localparam int HIDDEN_MAX = 32767;

   localparam logic signed [VALUE_W-1:0] BIAS_SCALE = 16'sd4096;

   localparam logic ACTION_PARAM   = 1'b0;
   localparam logic ACTION_FEATURE = 1'b1;

   localparam logic LAYER_HIDDEN = 1'b0;
   localparam logic LAYER_OUTPUT = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LAYER1 = 5'b00010,
      ST_DRAIN  = 5'b00100,
      ST_LAYER2 = 5'b01000,
      ST_FINISH = 5'b10000
   } tlmc_state_type;

   typedef struct packed {
      logic                valid;
      logic                layer;
      logic                bias;
      logic                w_zero;
      logic                last_term;
      logic                last_neuron;
      logic [NEURON_W-1:0] neuron;
   } tlmc_issue_type;

endpackage

// ===== src/tlmc_ram.sv =====
// tlmc_ram: generic single-write, single-read memory with registered read data
// no dependencies

module tlmc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tlmc_seq.sv =====
// tlmc_seq: sequencer that walks neurons and terms of both layers
// depends on tlmc_pkg; drives the memory read addresses and the mac pipeline tag

module tlmc_seq
   import tlmc_pkg::*;
#(
   parameter int N_INPUTS = 26,
   parameter int N_HIDDEN = 10,
   parameter int N_CLASSES = 10,
   parameter int PARAM_DEPTH = 512,
   parameter int PARAM_AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1,
   parameter int TERM_W = $clog2(((N_INPUTS > N_HIDDEN) ? N_INPUTS : N_HIDDEN) + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                launch,
   input  logic                done,
   output logic                busy,
   output tlmc_issue_type      issue,
   output logic [PARAM_AW-1:0] param_addr,
   output logic [TERM_W-1:0]   oper_idx
);

   localparam int B1_BASE = N_HIDDEN * N_INPUTS;
   localparam int W2_BASE = B1_BASE + N_HIDDEN;
   localparam int B2_BASE = W2_BASE + N_CLASSES * N_HIDDEN;
   localparam int LAYOUT_END = B2_BASE + N_CLASSES;
   localparam int ADDR_SPAN = (LAYOUT_END > PARAM_DEPTH) ? LAYOUT_END : PARAM_DEPTH;
   localparam int ADDR_W = $clog2(ADDR_SPAN + 1);
   localparam int DRAIN_LAST = 2;

   tlmc_state_type      state_ff, state_in;
   logic [TERM_W-1:0]   term_ff, term_in;
   logic [NEURON_W-1:0] neuron_ff, neuron_in;
   logic [1:0]          drain_ff, drain_in;

   logic                issuing;
   logic                is_bias;
   logic                term_end;
   logic                neuron_end;
   logic [TERM_W-1:0]   j_idx;
   logic [ADDR_W-1:0]   full_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         term_ff   <= '0;
         neuron_ff <= '0;
         drain_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         term_ff   <= term_in;
         neuron_ff <= neuron_in;
         drain_ff  <= drain_in;
      end
   end

   always_comb begin
      issuing    = (state_ff == ST_LAYER1) || (state_ff == ST_LAYER2);
      is_bias    = (term_ff == '0);
      j_idx      = term_ff - TERM_W'(1);
      if (state_ff == ST_LAYER2) begin
         term_end   = (term_ff == TERM_W'(N_HIDDEN));
         neuron_end = (neuron_ff == NEURON_W'(N_CLASSES - 1));
         if (is_bias) begin
            full_addr = ADDR_W'(B2_BASE) + ADDR_W'(neuron_ff);
         end else begin
            full_addr = ADDR_W'(W2_BASE) + ADDR_W'(neuron_ff) * ADDR_W'(N_HIDDEN)
                        + ADDR_W'(j_idx);
         end
      end else begin
         term_end   = (term_ff == TERM_W'(N_INPUTS));
         neuron_end = (neuron_ff == NEURON_W'(N_HIDDEN - 1));
         if (is_bias) begin
            full_addr = ADDR_W'(B1_BASE) + ADDR_W'(neuron_ff);
         end else begin
            full_addr = ADDR_W'(neuron_ff) * ADDR_W'(N_INPUTS) + ADDR_W'(j_idx);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      term_in   = term_ff;
      neuron_in = neuron_ff;
      drain_in  = drain_ff;
      case (state_ff)
         ST_IDLE: begin
            term_in   = '0;
            neuron_in = '0;
            if (launch) begin
               state_in = ST_LAYER1;
            end
         end
         ST_LAYER1, ST_LAYER2: begin
            if (term_end) begin
               term_in = '0;
               if (neuron_end) begin
                  neuron_in = '0;
                  drain_in  = '0;
                  state_in  = (state_ff == ST_LAYER1) ? ST_DRAIN : ST_FINISH;
               end else begin
                  neuron_in = neuron_ff + NEURON_W'(1);
               end
            end else begin
               term_in = term_ff + TERM_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + 2'd1;
            if (drain_ff == 2'(DRAIN_LAST)) begin
               state_in = ST_LAYER2;
            end
         end
         ST_FINISH: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      issue.valid       = issuing;
      issue.layer       = (state_ff == ST_LAYER2) ? LAYER_OUTPUT : LAYER_HIDDEN;
      issue.bias        = is_bias;
      issue.w_zero      = !(32'(full_addr) < PARAM_DEPTH);
      issue.last_term   = term_end;
      issue.last_neuron = neuron_end;
      issue.neuron      = neuron_ff;
   end

   assign param_addr = PARAM_AW'(full_addr);
   assign oper_idx   = j_idx;
   assign busy       = (state_ff != ST_IDLE);

endmodule

// ===== src/tlmc_mac.sv =====
// tlmc_mac: shared multiply-accumulate pipeline, rounding, relu and argmax
// depends on tlmc_pkg; fed by tlmc_seq tags and the memory read data

module tlmc_mac
   import tlmc_pkg::*;
#(
   parameter int N_HIDDEN = 10,
   parameter int HID_AW = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tlmc_issue_type             issue,
   input  logic [VALUE_W-1:0]         param_data,
   input  logic [VALUE_W-1:0]         feat_data,
   input  logic [VALUE_W-1:0]         hid_data,
   output logic                       hid_wr_en,
   output logic [HID_AW-1:0]          hid_wr_addr,
   output logic [VALUE_W-1:0]         hid_wr_data,
   output logic                       done,
   output logic                       rsp_valid,
   output logic [CLASS_W-1:0]         rsp_class_index,
   output logic signed [LOGIT_W-1:0]  rsp_best_logit
);

   localparam int Q_W = ACC_W - FRAC_BITS;
   localparam logic signed [Q_W-1:0] HID_MAX_Q = Q_W'(HIDDEN_MAX);

   tlmc_issue_type tag1_ff, tag2_ff, tag3_ff;

   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [NEURON_W-1:0]       best_idx_ff, best_idx_in;
   logic signed [LOGIT_W-1:0] best_val_ff, best_val_in;
   logic                      rsp_valid_ff;
   logic [CLASS_W-1:0]        rsp_class_ff;
   logic signed [LOGIT_W-1:0] rsp_logit_ff;

   logic signed [VALUE_W-1:0] w_op;
   logic signed [VALUE_W-1:0] x_op;
   logic signed [ACC_W-1:0]   acc_round;
   logic signed [Q_W-1:0]     q_val;
   logic signed [LOGIT_W-1:0] logit;
   logic                      finish;
   logic                      take_best;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         tag3_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff      <= issue;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      if (done) begin
         rsp_class_ff <= CLASS_W'(best_idx_in);
         rsp_logit_ff <= best_val_in;
      end
   end

   // operand select and product
   always_comb begin
      w_op = tag1_ff.w_zero ? '0 : $signed(param_data);
      if (tag1_ff.bias) begin
         x_op = BIAS_SCALE;
      end else if (tag1_ff.layer == LAYER_OUTPUT) begin
         x_op = $signed(hid_data);
      end else begin
         x_op = $signed(feat_data);
      end
      prod_in = w_op * x_op;
   end

   // accumulate, bias term restarts the sum
   always_comb begin
      if (tag2_ff.bias) begin
         acc_in = ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // round half up, relu and saturate, argmax
   always_comb begin
      acc_round = acc_ff + ACC_W'(ROUND_HALF);
      q_val     = acc_round[ACC_W-1:FRAC_BITS];
      logit     = LOGIT_W'(q_val);
      finish    = tag3_ff.valid && tag3_ff.last_term;

      hid_wr_en   = finish && (tag3_ff.layer == LAYER_HIDDEN);
      hid_wr_addr = HID_AW'(tag3_ff.neuron);
      if (q_val < 0) begin
         hid_wr_data = '0;
      end else if (q_val > HID_MAX_Q) begin
         hid_wr_data = VALUE_W'(HIDDEN_MAX);
      end else begin
         hid_wr_data = q_val[VALUE_W-1:0];
      end

      take_best   = (tag3_ff.neuron == '0) || (logit > best_val_ff);
      best_idx_in = best_idx_ff;
      best_val_in = best_val_ff;
      if (finish && (tag3_ff.layer == LAYER_OUTPUT) && take_best) begin
         best_idx_in = tag3_ff.neuron;
         best_val_in = logit;
      end
      done = finish && (tag3_ff.layer == LAYER_OUTPUT) && tag3_ff.last_neuron;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_class_index = rsp_class_ff;
   assign rsp_best_logit  = rsp_logit_ff;

endmodule

// ===== src/two_layer_mlp_classifier.sv =====
// two_layer_mlp_classifier: top level of the dense 26-10-10 network with argmax
// depends on tlmc_pkg, tlmc_ram, tlmc_seq and tlmc_mac

// Parameter and feature writes are taken only while busy is low. A feature request with
// last set starts inference: busy then stays high while the single multiply-accumulate
// unit works through both layers, one product per cycle outside the drain between the
// layers, bias terms included. The result shows for one cycle with rsp_valid in the
// cycle busy falls and is not held: the receiver must take it then. Memories are not
// cleared at reset; every weight, bias and feature used must be written first.

module two_layer_mlp_classifier
   import tlmc_pkg::*;
#(
   parameter int N_INPUTS = 26,
   parameter int N_HIDDEN = 10,
   parameter int N_CLASSES = 10,
   parameter int PARAM_DEPTH = 512
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic [INDEX_W-1:0]        req_index,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      req_last,
   output logic                      rsp_valid,
   output logic [CLASS_W-1:0]        rsp_class_index,
   output logic signed [LOGIT_W-1:0] rsp_best_logit
);

   localparam int PARAM_AW = (PARAM_DEPTH > 1) ? $clog2(PARAM_DEPTH) : 1;
   localparam int FEAT_AW = (N_INPUTS > 1) ? $clog2(N_INPUTS) : 1;
   localparam int HID_AW = (N_HIDDEN > 1) ? $clog2(N_HIDDEN) : 1;
   localparam int TERM_W = $clog2(((N_INPUTS > N_HIDDEN) ? N_INPUTS : N_HIDDEN) + 1);

   logic                accept;
   logic                launch;
   logic                param_wr;
   logic                feat_wr;
   logic                done;
   tlmc_issue_type      issue;
   logic [PARAM_AW-1:0] param_addr;
   logic [TERM_W-1:0]   oper_idx;
   logic [VALUE_W-1:0]  param_data;
   logic [VALUE_W-1:0]  feat_data;
   logic [VALUE_W-1:0]  hid_data;
   logic                hid_wr_en;
   logic [HID_AW-1:0]   hid_wr_addr;
   logic [VALUE_W-1:0]  hid_wr_data;

   assign accept   = start && !busy;
   assign param_wr = accept && (req_action == ACTION_PARAM) && (32'(req_index) < PARAM_DEPTH);
   assign feat_wr  = accept && (req_action == ACTION_FEATURE) && (32'(req_index) < N_INPUTS);
   assign launch   = accept && (req_action == ACTION_FEATURE) && req_last;

   tlmc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (PARAM_DEPTH)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (param_wr),
      .wr_addr (PARAM_AW'(req_index)),
      .wr_data (req_value),
      .rd_addr (param_addr),
      .rd_data (param_data)
   );

   tlmc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (N_INPUTS)
   ) u_feat_ram (
      .clock   (clock),
      .wr_en   (feat_wr),
      .wr_addr (FEAT_AW'(req_index)),
      .wr_data (req_value),
      .rd_addr (FEAT_AW'(oper_idx)),
      .rd_data (feat_data)
   );

   tlmc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (N_HIDDEN)
   ) u_hid_ram (
      .clock   (clock),
      .wr_en   (hid_wr_en),
      .wr_addr (hid_wr_addr),
      .wr_data (hid_wr_data),
      .rd_addr (HID_AW'(oper_idx)),
      .rd_data (hid_data)
   );

   tlmc_seq #(
      .N_INPUTS    (N_INPUTS),
      .N_HIDDEN    (N_HIDDEN),
      .N_CLASSES   (N_CLASSES),
      .PARAM_DEPTH (PARAM_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .launch     (launch),
      .done       (done),
      .busy       (busy),
      .issue      (issue),
      .param_addr (param_addr),
      .oper_idx   (oper_idx)
   );

   tlmc_mac #(
      .N_HIDDEN (N_HIDDEN)
   ) u_mac (
      .clock           (clock),
      .reset           (reset),
      .issue           (issue),
      .param_data      (param_data),
      .feat_data       (feat_data),
      .hid_data        (hid_data),
      .hid_wr_en       (hid_wr_en),
      .hid_wr_addr     (hid_wr_addr),
      .hid_wr_data     (hid_wr_data),
      .done            (done),
      .rsp_valid       (rsp_valid),
      .rsp_class_index (rsp_class_index),
      .rsp_best_logit  (rsp_best_logit)
   );

endmodule

// ===== bench/tb.sv =====
// tb: self-checking bench for two_layer_mlp_classifier, the 26-10-10 network with argmax
// depends on tlmc_pkg and the block's rtl; an in-bench predictor checks every class result

`timescale 1ns / 100ps

module tb;
   import tlmc_pkg::*;

   localparam int N_INPUTS    = 26;
   localparam int N_HIDDEN    = 10;
   localparam int N_CLASSES   = 10;
   localparam int PARAM_DEPTH = 512;
   localparam int B1_BASE     = N_HIDDEN * N_INPUTS;
   localparam int W2_BASE     = B1_BASE + N_HIDDEN;
   localparam int B2_BASE     = W2_BASE + N_CLASSES * N_HIDDEN;
   localparam int USED_PARAMS = B2_BASE + N_CLASSES;

   localparam int RANDOM_ITEMS   = 1250;
   localparam int QUIET_TAIL     = 150;
   localparam int DRAIN_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam longint LOGIT_HI = (longint'(1) <<< (LOGIT_W - 1)) - 1;
   localparam longint LOGIT_LO = -(longint'(1) <<< (LOGIT_W - 1));

   typedef struct {
      logic [CLASS_W-1:0]        class_index;
      logic signed [LOGIT_W-1:0] best_logit;
   } winner_type;

   class argmax_scoreboard;
      logic signed [VALUE_W-1:0] param_mem [PARAM_DEPTH];
      logic signed [VALUE_W-1:0] feature_mem [N_INPUTS];
      winner_type pending_winners[$];
      int requests = 0;
      int inferences = 0;
      int checked = 0;
      int errors = 0;
      int ties = 0;
      int hidden_clamps = 0;
      int relu_zeros = 0;

      function longint param_at(int addr);
         return (addr < PARAM_DEPTH) ? longint'(param_mem[addr]) : 64'sd0;
      endfunction

      function int pending();
         return pending_winners.size();
      endfunction

      function void note_request(logic action, logic [INDEX_W-1:0] index,
                                 logic signed [VALUE_W-1:0] value, logic last);
         longint acc;
         longint r;
         longint best_val;
         longint hid [N_HIDDEN];
         longint logit [N_CLASSES];
         int best;
         int equal_count;
         winner_type w;
         requests++;
         if (action == ACTION_PARAM) begin
            if (index < PARAM_DEPTH)
               param_mem[index] = value;
            return;
         end
         if (index < N_INPUTS)
            feature_mem[index] = value;
         if (!last)
            return;
         inferences++;
         for (int h = 0; h < N_HIDDEN; h++) begin
            acc = param_at(B1_BASE + h) * longint'(BIAS_SCALE);
            for (int j = 0; j < N_INPUTS; j++)
               acc += param_at(h * N_INPUTS + j) * longint'(feature_mem[j]);
            r = (acc + ROUND_HALF) >>> FRAC_BITS;
            if (r < 0) begin
               r = 0;
               relu_zeros++;
            end
            if (r > HIDDEN_MAX) begin
               r = HIDDEN_MAX;
               hidden_clamps++;
            end
            hid[h] = r;
         end
         best = 0;
         best_val = 0;
         for (int c = 0; c < N_CLASSES; c++) begin
            acc = param_at(B2_BASE + c) * longint'(BIAS_SCALE);
            for (int h = 0; h < N_HIDDEN; h++)
               acc += param_at(W2_BASE + c * N_HIDDEN + h) * hid[h];
            r = (acc + ROUND_HALF) >>> FRAC_BITS;
            if (r > LOGIT_HI)
               r = LOGIT_HI;
            if (r < LOGIT_LO)
               r = LOGIT_LO;
            logit[c] = r;
            if (c == 0 || r > best_val) begin
               best = c;
               best_val = r;
            end
         end
         equal_count = 0;
         foreach (logit[c])
            if (logit[c] == best_val)
               equal_count++;
         if (equal_count > 1)
            ties++;
         w.class_index = best[CLASS_W-1:0];
         w.best_logit = best_val[LOGIT_W-1:0];
         pending_winners.push_back(w);
      endfunction

      function void check_winner(logic [CLASS_W-1:0] cls, logic signed [LOGIT_W-1:0] logit);
         winner_type w;
         if (pending_winners.size() == 0) begin
            errors++;
            $display("%0t: result with no inference pending, class %0d logit %0d",
                     $time, cls, logit);
            return;
         end
         w = pending_winners.pop_front();
         checked++;
         if (cls !== w.class_index) begin
            errors++;
            $display("%0t: class_index mismatch, expected %0d, actual %0d",
                     $time, w.class_index, cls);
         end
         if (logit !== w.best_logit) begin
            errors++;
            $display("%0t: best_logit mismatch, expected %0d, actual %0d",
                     $time, w.best_logit, logit);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_action = ACTION_PARAM;
   logic [INDEX_W-1:0]        req_index = '0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last = 1'b0;
   logic                      rsp_valid;
   logic [CLASS_W-1:0]        rsp_class_index;
   logic signed [LOGIT_W-1:0] rsp_best_logit;

   argmax_scoreboard sb = new();
   int idle_count = 0;
   int counted_items = 0;
   bit idle_on = 1'b1;

   two_layer_mlp_classifier #(
      .N_INPUTS(N_INPUTS),
      .N_HIDDEN(N_HIDDEN),
      .N_CLASSES(N_CLASSES),
      .PARAM_DEPTH(PARAM_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_action(req_action),
      .req_index(req_index),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_class_index(rsp_class_index),
      .rsp_best_logit(rsp_best_logit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_action, req_index, req_value, req_last);
         if (rsp_valid)
            sb.check_winner(rsp_class_index, rsp_best_logit);
         if ((start && !busy) || rsp_valid)
            idle_count <= 0;
         else
            idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, idle_count);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   function automatic int rand_value();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3, 4, 5: return int'($urandom_range(0, 8191)) - 4096;
         6, 7: return int'($urandom_range(0, 2047)) - 1024;
         default: return int'($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic send_request(input logic action, input int index, input int value,
                               input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 11)) begin
            @(negedge clock);
            start <= 1'b0;
         end
      end
      @(negedge clock);
      start <= 1'b1;
      req_action <= action;
      req_index <= index[INDEX_W-1:0];
      req_value <= value[VALUE_W-1:0];
      req_last <= last;
      do @(posedge clock); while (busy);
      counted_items++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   // zero features and non-positive hidden biases force equal hidden outputs of zero,
   // so the logits reduce to the output biases drawn from two values
   task automatic run_tie_case();
      for (int h = 0; h < N_HIDDEN; h++)
         send_request(ACTION_PARAM, B1_BASE + h, -int'($urandom_range(0, 4096)), 1'b0);
      for (int c = 0; c < N_CLASSES; c++)
         send_request(ACTION_PARAM, B2_BASE + c, int'($urandom_range(0, 1)) * 100, 1'b0);
      for (int j = 0; j < N_INPUTS; j++)
         send_request(ACTION_FEATURE, j, 0, j == N_INPUTS - 1);
   endtask

   task automatic reload_region();
      int base;
      int count;
      case ($urandom_range(0, 3))
         0: begin
            base = $urandom_range(0, N_HIDDEN - 1) * N_INPUTS;
            count = N_INPUTS;
         end
         1: begin
            base = B1_BASE;
            count = N_HIDDEN;
         end
         2: begin
            base = W2_BASE + $urandom_range(0, N_CLASSES - 1) * N_HIDDEN;
            count = N_HIDDEN;
         end
         default: begin
            base = B2_BASE;
            count = N_CLASSES;
         end
      endcase
      for (int k = 0; k < count; k++)
         send_request(ACTION_PARAM, base + k, rand_value(), 1'b0);
   endtask

   initial begin
      int burst;
      int pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // full parameter and feature load, so no inference reads an unwritten word
      for (int a = 0; a < USED_PARAMS; a++)
         send_request(ACTION_PARAM, a, rand_value(), $urandom_range(0, 1));
      for (int j = 0; j < N_INPUTS; j++)
         send_request(ACTION_FEATURE, j, rand_value(), j == N_INPUTS - 1);

      // directed corners
      send_request(ACTION_FEATURE, 0, -32768, 1'b0);
      send_request(ACTION_FEATURE, N_INPUTS - 1, 32767, 1'b1);
      send_request(ACTION_PARAM, PARAM_DEPTH - 1, 32767, 1'b1);
      send_request(ACTION_PARAM, USED_PARAMS, -32768, 1'b0);
      send_request(ACTION_PARAM, 0, 32767, 1'b0);
      send_request(ACTION_PARAM, B1_BASE, -32768, 1'b0);
      send_request(ACTION_PARAM, W2_BASE, 32767, 1'b0);
      send_request(ACTION_PARAM, B2_BASE + N_CLASSES - 1, 32767, 1'b0);
      send_request(ACTION_FEATURE, N_INPUTS, 1234, 1'b0);
      send_request(ACTION_FEATURE, 2 ** INDEX_W - 1, -1, 1'b1);
      send_request(ACTION_FEATURE, 13, -1, 1'b0);
      send_request(ACTION_FEATURE, 12, 4096, 1'b1);
      for (int j = 0; j < 4; j++)
         send_request(ACTION_FEATURE, j, 32767, 1'b0);
      send_request(ACTION_FEATURE, N_INPUTS, 0, 1'b1);
      wait_drained();
      run_tie_case();
      wait_drained();

      while (counted_items < RANDOM_ITEMS) begin
         idle_on = (counted_items < RANDOM_ITEMS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            burst = $urandom_range(0, N_INPUTS);
            repeat (burst)
               send_request(ACTION_FEATURE, $urandom_range(0, N_INPUTS - 1), rand_value(), 1'b0);
            send_request(ACTION_FEATURE, $urandom_range(0, N_INPUTS - 1), rand_value(), 1'b1);
         end else if (pick < 60) begin
            burst = $urandom_range(1, 12);
            repeat (burst)
               send_request(ACTION_PARAM, $urandom_range(0, PARAM_DEPTH - 1), rand_value(),
                            $urandom_range(0, 1));
         end else if (pick < 70) begin
            reload_region();
         end else if (pick < 74) begin
            run_tie_case();
         end else if (pick < 84) begin
            send_request(ACTION_FEATURE, $urandom_range(N_INPUTS, 2 ** INDEX_W - 1),
                         rand_value(), 1'b0);
            send_request(ACTION_PARAM, $urandom_range(USED_PARAMS, PARAM_DEPTH - 1),
                         rand_value(), 1'b1);
         end else if (pick < 97) begin
            send_request(ACTION_FEATURE, $urandom_range(N_INPUTS, 2 ** INDEX_W - 1),
                         rand_value(), 1'b1);
         end else begin
            wait_drained();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("run covered %0d requests and %0d checked inferences", sb.requests, sb.checked);
      $display("%0d inferences with tied winners, %0d hidden clamps, %0d relu zeros",
               sb.ties, sb.hidden_clamps, sb.relu_zeros);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
